// File: hw/rtl/obcg_pkg.sv
// Shared types, constants and small lookup functions for the oriented box
// corner generator. No dependencies; every other file refers to it by scope.
package obcg_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;

  // Q16 angle constants and CORDIC setup
  localparam int Q16_PI      = 205887;
  localparam int Q16_TWO_PI  = 411775;
  localparam int Q16_HALF_PI = 102944;
  localparam int CORDIC_X0   = 39797;
  localparam int CORDIC_STEPS = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;

  // Width of the angle after scaling to Q16 and of the turn-reduction loop
  localparam int RED_W = (ANGLE_BITS + 5 > 21) ? ANGLE_BITS + 5 : 21;
  localparam int RED_STEPS = (ANGLE_BITS - 15 > 1) ? ANGLE_BITS - 15 : 1;

  // Datapath widths
  localparam int SC_W  = 20;                 // CORDIC x/y/z, sine, cosine
  localparam int ROT_W = 20;                 // rotation matrix entries Q16
  localparam int LEN_W = 16;                 // box extents Q8.8
  localparam int PRD_W = ROT_W + LEN_W + 1;  // entry times extent
  localparam int ACC_W = PRD_W + 3;          // three-term corner sum
  localparam int RND_W = ACC_W - 17;         // sum rounded to Q8
  localparam int SUM_W = ((RND_W > COORD_BITS) ? RND_W : COORD_BITS) + 1;

  localparam logic [3:0] LAST_CORNER = 4'd7;
  localparam logic [3:0] LAST_FACE_VERTEX = 4'd15;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SC_W-1:0]       sc_t;
  typedef logic signed [ROT_W-1:0]      rot_t;

  // Fields that ride along with the angles until the corner stage
  typedef struct packed {
    logic               mode;
    coord_t             off_x;
    coord_t             off_y;
    coord_t             off_z;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   wid;
    logic [LEN_W-1:0]   hgt;
  } side_t;

  // CORDIC arctangent table, Q16
  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] a;
    case (i)
      4'd0:  a = 17'd51472;
      4'd1:  a = 17'd30386;
      4'd2:  a = 17'd16055;
      4'd3:  a = 17'd8150;
      4'd4:  a = 17'd4091;
      4'd5:  a = 17'd2047;
      4'd6:  a = 17'd1024;
      4'd7:  a = 17'd512;
      4'd8:  a = 17'd256;
      4'd9:  a = 17'd128;
      4'd10: a = 17'd64;
      4'd11: a = 17'd32;
      4'd12: a = 17'd16;
      4'd13: a = 17'd8;
      4'd14: a = 17'd4;
      default: a = 17'd2;
    endcase
    return a;
  endfunction

  // Corner visited at each position of the side-face run
  function automatic logic [2:0] face_corner(input logic [3:0] k);
    logic [2:0] c;
    case (k)
      4'd0:  c = 3'd0;
      4'd1:  c = 3'd1;
      4'd2:  c = 3'd5;
      4'd3:  c = 3'd4;
      4'd4:  c = 3'd1;
      4'd5:  c = 3'd2;
      4'd6:  c = 3'd6;
      4'd7:  c = 3'd5;
      4'd8:  c = 3'd2;
      4'd9:  c = 3'd3;
      4'd10: c = 3'd7;
      4'd11: c = 3'd6;
      4'd12: c = 3'd3;
      4'd13: c = 3'd0;
      4'd14: c = 3'd4;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/obcg_if.sv
// Request channel interfaces for the box input and the vertex output.
// Depends on obcg_pkg for field types.
interface obcg_in_if;
  logic                valid;
  logic                ready;
  logic                mode;
  obcg_pkg::angle_t    angle_x;
  obcg_pkg::angle_t    angle_y;
  obcg_pkg::angle_t    angle_z;
  obcg_pkg::coord_t    offset_x;
  obcg_pkg::coord_t    offset_y;
  obcg_pkg::coord_t    offset_z;
  logic [15:0]         box_length;
  logic [15:0]         box_width;
  logic [15:0]         box_height;

  modport source(output valid, mode, angle_x, angle_y, angle_z, offset_x, offset_y,
                 offset_z, box_length, box_width, box_height, input ready);
  modport sink(input valid, mode, angle_x, angle_y, angle_z, offset_x, offset_y,
               offset_z, box_length, box_width, box_height, output ready);
endinterface

interface obcg_out_if;
  logic                valid;
  logic                ready;
  obcg_pkg::coord_t    point_x;
  obcg_pkg::coord_t    point_y;
  obcg_pkg::coord_t    point_z;
  logic [3:0]          vertex_number;
  logic                last_vertex;

  modport source(output valid, point_x, point_y, point_z, vertex_number, last_vertex,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, vertex_number, last_vertex,
               output ready);
endinterface

// File: hw/rtl/oriented_box_corner_generator.sv
// Top level of the oriented box corner generator: CORDIC, matrix and corner
// stages. Depends on obcg_pkg, obcg_if, obcg_sincos, obcg_rotmat, obcg_corner.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      mode, angle_x/y/z, offset_x/y/z, box_length/width/height
//  out_ch   out  valid/ready      point_x/y/z, vertex_number, last_vertex
//
// A box yields 8 (mode 0) or 16 (mode 1) vertices, one per cycle while out_ch
// is ready; the vertex serializer takes the next box only as the last vertex of the current one leaves it.
// From an accepted request to out_ch the first vertex passes 11 register stages
// (5 CORDIC, 2 matrix, 1 scale, serializer, round, output). Reset (rst_n
// low, synchronous) clears all valid bits.
// A stall on out_ch freezes the whole pipeline.
module oriented_box_corner_generator (
  input  logic       clk,
  input  logic       rst_n,
  obcg_in_if.sink    in_ch,
  obcg_out_if.source out_ch
);

  logic             up_en;
  obcg_pkg::angle_t ang [3];
  obcg_pkg::side_t  side;
  logic             sc_v, rm_v;
  obcg_pkg::sc_t    sc_sin [3];
  obcg_pkg::sc_t    sc_cos [3];
  obcg_pkg::side_t  sc_side, rm_side;
  obcg_pkg::rot_t   rm_rot [9];

  // Gather request fields
  assign ang[0] = in_ch.angle_x;
  assign ang[1] = in_ch.angle_y;
  assign ang[2] = in_ch.angle_z;
  assign side.mode  = in_ch.mode;
  assign side.off_x = in_ch.offset_x;
  assign side.off_y = in_ch.offset_y;
  assign side.off_z = in_ch.offset_z;
  assign side.len   = in_ch.box_length;
  assign side.wid   = in_ch.box_width;
  assign side.hgt   = in_ch.box_height;
  assign in_ch.ready = up_en;

  obcg_sincos u_sincos (
    .clk, .rst_n, .en(up_en),
    .in_v(in_ch.valid), .in_angle(ang), .in_side(side),
    .out_v(sc_v), .out_sin(sc_sin), .out_cos(sc_cos), .out_side(sc_side)
  );

  obcg_rotmat u_rotmat (
    .clk, .rst_n, .en(up_en),
    .in_v(sc_v), .in_sin(sc_sin), .in_cos(sc_cos), .in_side(sc_side),
    .out_v(rm_v), .out_rot(rm_rot), .out_side(rm_side)
  );

  obcg_corner u_corner (
    .clk, .rst_n,
    .in_v(rm_v), .in_rot(rm_rot), .in_side(rm_side),
    .up_en(up_en), .out_ch(out_ch)
  );

endmodule

// File: hw/rtl/obcg_sincos.sv
// Three-lane pipelined CORDIC: turn reduction, then four steps per stage.
// Depends on obcg_pkg; side fields travel alongside unchanged.
module obcg_sincos (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  obcg_pkg::angle_t    in_angle [3],
  input  obcg_pkg::side_t     in_side,
  output logic                out_v,
  output obcg_pkg::sc_t       out_sin [3],
  output obcg_pkg::sc_t       out_cos [3],
  output obcg_pkg::side_t     out_side
);

  localparam int CW = obcg_pkg::SC_W;
  localparam int RW = obcg_pkg::RED_W;
  localparam int NS = obcg_pkg::CORDIC_STAGES;
  localparam int SPS = obcg_pkg::STEPS_PER_STAGE;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } lane_t;

  lane_t           st_r   [NS+1][3];
  logic            v_r    [NS+1];
  obcg_pkg::side_t side_r [NS+1];

  // Wrap into one turn, then fold into [-pi/2, pi/2] with a sign flip
  function automatic lane_t reduce(input obcg_pkg::angle_t a);
    logic signed [RW-1:0] r;
    logic [RW-1:0]        mag;
    logic                 neg;
    lane_t                l;
    r = RW'(a) <<< 4;
    neg = r[RW-1];
    mag = neg ? RW'(-r) : RW'(r);
    for (int k = obcg_pkg::RED_STEPS - 1; k >= 0; k--) begin
      if (64'(mag) >= (64'(obcg_pkg::Q16_TWO_PI) << k)) begin
        mag = mag - RW'(64'(obcg_pkg::Q16_TWO_PI) << k);
      end
    end
    r = neg ? -$signed(mag) : $signed(mag);
    if (r > RW'(obcg_pkg::Q16_PI)) begin
      r = r - RW'(obcg_pkg::Q16_TWO_PI);
    end else if (r < -RW'(obcg_pkg::Q16_PI)) begin
      r = r + RW'(obcg_pkg::Q16_TWO_PI);
    end
    l.flip = 1'b0;
    if (r > RW'(obcg_pkg::Q16_HALF_PI)) begin
      r = r - RW'(obcg_pkg::Q16_PI);
      l.flip = 1'b1;
    end else if (r < -RW'(obcg_pkg::Q16_HALF_PI)) begin
      r = r + RW'(obcg_pkg::Q16_PI);
      l.flip = 1'b1;
    end
    l.x = CW'(obcg_pkg::CORDIC_X0);
    l.y = '0;
    l.z = CW'(r);
    return l;
  endfunction

  // Run one stage worth of rotation steps
  function automatic lane_t iterate(input lane_t s, input int base);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    lane_t                l;
    l = s;
    for (int j = 0; j < SPS; j++) begin
      dx = l.y >>> (base + j);
      dy = l.x >>> (base + j);
      at = CW'(obcg_pkg::atan_q16(4'(base + j)));
      if (l.z >= 0) begin
        l.x = l.x - dx;
        l.y = l.y + dy;
        l.z = l.z - at;
      end else begin
        l.x = l.x + dx;
        l.y = l.y - dy;
        l.z = l.z + at;
      end
    end
    return l;
  endfunction

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NS; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int s = 1; s <= NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  // Advance lane data and side fields
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int n = 0; n < 3; n++) st_r[0][n] <= reduce(in_angle[n]);
      for (int s = 1; s <= NS; s++) begin
        side_r[s] <= side_r[s-1];
        for (int n = 0; n < 3; n++) st_r[s][n] <= iterate(st_r[s-1][n], (s - 1) * SPS);
      end
    end
  end

  // Undo the fold on the way out
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      out_cos[n] = st_r[NS][n].flip ? -st_r[NS][n].x : st_r[NS][n].x;
      out_sin[n] = st_r[NS][n].flip ? -st_r[NS][n].y : st_r[NS][n].y;
    end
  end

  assign out_v    = v_r[NS];
  assign out_side = side_r[NS];

endmodule

// File: hw/rtl/obcg_rotmat.sv
// Two-stage build of R = Rz*Ry*Rx from sines and cosines in Q16.
// Depends on obcg_pkg.
module obcg_rotmat (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  obcg_pkg::sc_t       in_sin [3],
  input  obcg_pkg::sc_t       in_cos [3],
  input  obcg_pkg::side_t     in_side,
  output logic                out_v,
  output obcg_pkg::rot_t      out_rot [9],
  output obcg_pkg::side_t     out_side
);

  localparam int PW = obcg_pkg::SC_W + obcg_pkg::ROT_W;

  logic            a_v_r, b_v_r;
  obcg_pkg::side_t a_side_r, b_side_r;
  obcg_pkg::rot_t  czcy_r, czsy_r, szcx_r, szcy_r, szsy_r, czcx_r;
  obcg_pkg::rot_t  cysx_r, cycx_r, szsx_r, czsx_r;
  obcg_pkg::sc_t   sx_r, cx_r, sy_r;
  obcg_pkg::rot_t  rot_r [9];

  // Q16 product rounded half up
  function automatic obcg_pkg::rot_t mulq(input obcg_pkg::sc_t a, input obcg_pkg::rot_t b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + PW'(32768);
    return obcg_pkg::ROT_W'(p >>> 16);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  // Stage A: pairwise products
  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= in_side;
      czcy_r <= mulq(in_cos[2], in_cos[1]);
      czsy_r <= mulq(in_cos[2], in_sin[1]);
      szcx_r <= mulq(in_sin[2], in_cos[0]);
      szcy_r <= mulq(in_sin[2], in_cos[1]);
      szsy_r <= mulq(in_sin[2], in_sin[1]);
      czcx_r <= mulq(in_cos[2], in_cos[0]);
      cysx_r <= mulq(in_cos[1], in_sin[0]);
      cycx_r <= mulq(in_cos[1], in_cos[0]);
      szsx_r <= mulq(in_sin[2], in_sin[0]);
      czsx_r <= mulq(in_cos[2], in_sin[0]);
      sx_r   <= in_sin[0];
      cx_r   <= in_cos[0];
      sy_r   <= in_sin[1];
    end
  end

  // Stage B: triple products and sums
  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r <= a_side_r;
      rot_r[0] <= czcy_r;
      rot_r[1] <= mulq(sx_r, czsy_r) - szcx_r;
      rot_r[2] <= mulq(cx_r, czsy_r) + szsx_r;
      rot_r[3] <= szcy_r;
      rot_r[4] <= mulq(sx_r, szsy_r) + czcx_r;
      rot_r[5] <= mulq(cx_r, szsy_r) - czsx_r;
      rot_r[6] <= -obcg_pkg::ROT_W'(sy_r);
      rot_r[7] <= cysx_r;
      rot_r[8] <= cycx_r;
    end
  end

  assign out_v    = b_v_r;
  assign out_side = b_side_r;
  always_comb begin
    for (int n = 0; n < 9; n++) out_rot[n] = rot_r[n];
  end

endmodule

// File: hw/rtl/obcg_corner.sv
// Scales the matrix by the box extents, then walks the corner run one vertex per cycle
// while out_ch is ready, with rounding, offset and saturation. Depends on obcg_pkg.
module obcg_corner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  input  obcg_pkg::rot_t      in_rot [9],
  input  obcg_pkg::side_t     in_side,
  output logic                up_en,
  obcg_out_if.source          out_ch
);

  localparam int PW = obcg_pkg::PRD_W;
  localparam int AW = obcg_pkg::ACC_W;
  localparam int RDW = obcg_pkg::RND_W;
  localparam int SW = obcg_pkg::SUM_W;
  localparam int CB = obcg_pkg::COORD_BITS;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  logic                  p_v_r, ser_v_r, t_v_r, o_v_r;
  logic signed [PW-1:0]  p_prd_r [9];
  obcg_pkg::side_t       p_side_r;
  logic signed [PW-1:0]  ser_prd_r [9];
  obcg_pkg::side_t       ser_side_r;
  logic [3:0]            ser_cnt_r;
  logic                  adv, ser_last;
  logic [2:0]            corner;
  logic signed [RDW-1:0] t_rnd_nxt [3];
  logic signed [RDW-1:0] t_rnd_r [3];
  obcg_pkg::coord_t      t_off_r [3];
  logic [3:0]            t_num_r, o_num_r;
  logic                  t_last_r, o_last_r;
  obcg_pkg::coord_t      o_pt_nxt [3];
  obcg_pkg::coord_t      o_pt_r [3];

  assign adv = !o_v_r || out_ch.ready;
  assign ser_last = ser_cnt_r == (ser_side_r.mode ? obcg_pkg::LAST_FACE_VERTEX
                                                  : obcg_pkg::LAST_CORNER);
  assign up_en = adv && (!ser_v_r || ser_last);

  // Stage P: entry times extent
  always_ff @(posedge clk) begin
    if (up_en) begin
      p_side_r <= in_side;
      for (int r = 0; r < 3; r++) begin
        p_prd_r[3*r]   <= PW'(in_rot[3*r])   * PW'($signed({1'b0, in_side.len}));
        p_prd_r[3*r+1] <= PW'(in_rot[3*r+1]) * PW'($signed({1'b0, in_side.wid}));
        p_prd_r[3*r+2] <= PW'(in_rot[3*r+2]) * PW'($signed({1'b0, in_side.hgt}));
      end
    end
  end

  // Serializer: hold one box and step through its vertices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r     <= 1'b0;
      ser_v_r   <= 1'b0;
      ser_cnt_r <= '0;
      t_v_r     <= 1'b0;
      o_v_r     <= 1'b0;
    end else begin
      if (up_en) p_v_r <= in_v;
      if (adv) begin
        t_v_r <= ser_v_r;
        o_v_r <= t_v_r;
        if (up_en) begin
          ser_v_r   <= p_v_r;
          ser_cnt_r <= '0;
        end else if (ser_v_r) begin
          ser_cnt_r <= ser_cnt_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_en) begin
      ser_side_r <= p_side_r;
      for (int n = 0; n < 9; n++) ser_prd_r[n] <= p_prd_r[n];
    end
  end

  // Tail: signed corner sum rounded to Q8
  always_comb begin
    logic signed [AW-1:0] acc;
    corner = ser_side_r.mode ? obcg_pkg::face_corner(ser_cnt_r) : ser_cnt_r[2:0];
    for (int r = 0; r < 3; r++) begin
      acc = corner[1] ? -AW'(ser_prd_r[3*r]) : AW'(ser_prd_r[3*r]);
      acc = acc + ((corner[1] ^ corner[0]) ? -AW'(ser_prd_r[3*r+1])
                                           : AW'(ser_prd_r[3*r+1]));
      if (corner[2]) acc = acc + (AW'(ser_prd_r[3*r+2]) <<< 1);
      acc = acc + AW'(65536);
      t_rnd_nxt[r] = RDW'(acc >>> 17);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) t_rnd_r[r] <= t_rnd_nxt[r];
      t_off_r[0] <= ser_side_r.off_x;
      t_off_r[1] <= ser_side_r.off_y;
      t_off_r[2] <= ser_side_r.off_z;
      t_num_r    <= ser_cnt_r;
      t_last_r   <= ser_last;
    end
  end

  // Output: add offset and clamp to the coordinate range
  always_comb begin
    logic signed [SW-1:0] sum;
    for (int r = 0; r < 3; r++) begin
      sum = SW'(t_rnd_r[r]) + SW'(t_off_r[r]);
      if (sum > SAT_HI) begin
        o_pt_nxt[r] = {1'b0, {(CB-1){1'b1}}};
      end else if (sum < SAT_LO) begin
        o_pt_nxt[r] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        o_pt_nxt[r] = CB'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) o_pt_r[r] <= o_pt_nxt[r];
      o_num_r  <= t_num_r;
      o_last_r <= t_last_r;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.point_x       = o_pt_r[0];
  assign out_ch.point_y       = o_pt_r[1];
  assign out_ch.point_z       = o_pt_r[2];
  assign out_ch.vertex_number = o_num_r;
  assign out_ch.last_vertex   = o_last_r;

  // A run ends only at the eighth corner or the sixteenth face vertex
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_last_r) |-> (o_num_r == obcg_pkg::LAST_CORNER ||
                             o_num_r == obcg_pkg::LAST_FACE_VERTEX))
    else $error("last vertex at wrong position");

  // In mode 0 the serializer count stays inside the corner run
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_v_r && !ser_side_r.mode) |-> (ser_cnt_r <= obcg_pkg::LAST_CORNER))
    else $error("corner count overran");

  // A taken vertex that is not last is followed at once by its successor
  a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && out_ch.ready && !o_last_r) |=>
      (o_v_r && o_num_r == $past(o_num_r) + 4'd1))
    else $error("gap inside a vertex run");

endmodule
